// File: design/sci_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the segment/circle intersection pipeline.
// Used by the top level, the square root pipeline and the divider pipeline.
package sci_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int RAD_W          = 16;
    localparam int OUT_W          = 14;
    localparam int CNT_W          = 2;
    localparam int OUT_MIN        = -8192;
    localparam int OUT_MAX        = 8191;

    typedef struct packed {
        logic en;
    } t_pipe_ctl;

    function automatic int f_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// File: design/sci_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit resolved per stage.
// Depends on sci_pkg for the pipeline control struct.
module sci_sqrt #(
    parameter int SW = 30
) (
    input  logic               i_clk,
    input  sci_pkg::t_pipe_ctl i_ctl,
    input  logic [2*SW-1:0]    i_radicand,
    output logic [SW-1:0]      o_root
);

    logic [SW:0]     r_rem  [0:SW-1];
    logic [SW-1:0]   r_root [0:SW];
    logic [2*SW-1:0] r_rad  [0:SW-1];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_rad[0]  <= i_radicand;
        end
    end

    for (genvar k = 1; k <= SW; k++) begin : g_stage
        logic [SW+2:0] n_cand;
        logic [SW+2:0] n_trial;
        logic [SW+2:0] n_diff;
        logic          n_ge;

        always_comb begin
            n_cand  = {r_rem[k-1], r_rad[k-1][2*SW-1 -: 2]};
            n_trial = {1'b0, r_root[k-1], 2'b01};
            n_diff  = n_cand - n_trial;
            n_ge    = (n_cand >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_root[k] <= {r_root[k-1][SW-2:0], n_ge};
            end
        end

        if (k < SW) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    r_rem[k] <= n_ge ? n_diff[SW:0] : n_cand[SW:0];
                    r_rad[k] <= {r_rad[k-1][2*SW-3:0], 2'b00};
                end
            end
        end
    end

    assign o_root = r_root[SW];

endmodule

// File: design/sci_div.sv
`timescale 1ns / 1ps
// Pipelined signed divider giving trunc(num * 2^FB / den), one quotient bit per stage.
// Depends on sci_pkg for the pipeline control struct.
module sci_div #(
    parameter int TW  = 33,
    parameter int FB  = 16,
    parameter int QW  = 29,
    parameter int DNW = 29
) (
    input  logic               i_clk,
    input  sci_pkg::t_pipe_ctl i_ctl,
    input  logic signed [TW-1:0] i_num,
    input  logic [DNW-1:0]     i_den,
    output logic signed [QW:0] o_quot
);

    localparam int NW = TW + FB;

    logic [TW-1:0]      n_mag;
    logic [NW-1:0]      n_num;
    logic [NW+DNW-1:0]  n_wide;

    logic [DNW-1:0] r_rem [0:QW-1];
    logic [QW-1:0]  r_nq  [0:QW];
    logic [DNW-1:0] r_den [0:QW-1];
    logic           r_neg [0:QW];
    logic signed [QW:0] r_quot;

    always_comb begin
        n_mag  = i_num[TW-1] ? TW'(-i_num) : TW'(i_num);
        n_num  = {n_mag, {FB{1'b0}}};
        n_wide = {{DNW{1'b0}}, n_num};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_rem[0] <= n_wide[QW +: DNW];
            r_nq[0]  <= n_num[QW-1:0];
            r_den[0] <= i_den;
            r_neg[0] <= i_num[TW-1];
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        logic [DNW:0] n_cand;
        logic [DNW:0] n_diff;
        logic         n_ge;

        always_comb begin
            n_cand = {r_rem[k-1], r_nq[k-1][QW-1]};
            n_diff = n_cand - {1'b0, r_den[k-1]};
            n_ge   = (n_cand >= {1'b0, r_den[k-1]});
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_nq[k]  <= {r_nq[k-1][QW-2:0], n_ge};
                r_neg[k] <= r_neg[k-1];
            end
        end

        if (k < QW) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    r_rem[k] <= n_ge ? n_diff[DNW-1:0] : n_cand[DNW-1:0];
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_quot <= r_neg[QW] ? -$signed({1'b0, r_nq[QW]}) : $signed({1'b0, r_nq[QW]});
        end
    end

    assign o_quot = r_quot;

endmodule

// File: design/segment_circle_intersection.sv
`timescale 1ns / 1ps
// Segment/circle intersection: top level pipeline with handshake and output register.
// Depends on sci_pkg, sci_sqrt and sci_div.
//
// The block takes one request per cycle while o_stall is low and returns one result
// per request, in order. SW is half the discriminant width (one root bit per stage of
// the square root pipeline) and QW = COORD_BITS + FRAC_BITS + 1 (one quotient bit per
// stage of the two parallel divider pipelines). A stall on the output while o_valid is
// high freezes the whole pipeline and raises o_stall in the same cycle; nothing is
// lost or repeated.
module segment_circle_intersection #(
    parameter int COORD_BITS = sci_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sci_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [COORD_BITS-1:0]             i_start_x,
    input  logic [COORD_BITS-1:0]             i_start_y,
    input  logic [COORD_BITS-1:0]             i_end_x,
    input  logic [COORD_BITS-1:0]             i_end_y,
    input  logic [COORD_BITS-1:0]             i_circle_x,
    input  logic [COORD_BITS-1:0]             i_circle_y,
    input  logic [sci_pkg::RAD_W-1:0]         i_circle_radius,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [sci_pkg::CNT_W-1:0]         o_hit_count,
    output logic signed [sci_pkg::OUT_W-1:0]  o_first_x,
    output logic signed [sci_pkg::OUT_W-1:0]  o_first_y,
    output logic signed [sci_pkg::OUT_W-1:0]  o_second_x,
    output logic signed [sci_pkg::OUT_W-1:0]  o_second_y,
    output logic                              o_vertical_flag
);

    localparam int CB   = COORD_BITS;
    localparam int FB   = FRAC_BITS;
    localparam int DW   = CB + 1;
    localparam int AW   = 2 * CB + 1;
    localparam int BW   = 2 * CB + 2;
    localparam int PRW  = 2 * DW;
    localparam int RRW  = 2 * sci_pkg::RAD_W;
    localparam int CW   = sci_pkg::f_max(2 * CB + 9, RRW) + 1;
    localparam int CLW  = CW / 2;
    localparam int HPW  = AW + 1 + CW - CLW;
    localparam int BBW  = 2 * BW;
    localparam int D8W  = sci_pkg::f_max(4 * CB + 11, AW + CW) + 1;
    localparam int SRW  = (D8W - 1) + ((D8W - 1) % 2);
    localparam int SW   = SRW / 2;
    localparam int LSQ  = SW + 1;
    localparam int TW   = sci_pkg::f_max(BW + 4, SW + 1) + 1;
    localparam int DNW  = AW + 4;
    localparam int QW   = CB + FB + 1;
    localparam int LDV  = QW + 2;
    localparam int MW   = DW + QW + 1;
    localparam int PW   = MW + 1;
    localparam int OW   = sci_pkg::OUT_W;

    typedef struct packed {
        logic [CB-1:0]          sx;
        logic [CB-1:0]          sy;
        logic signed [DW-1:0]   dx;
        logic signed [DW-1:0]   dy;
        logic [AW-1:0]          a;
        logic signed [BW-1:0]   b;
        logic                   vert;
    } t_geo;

    typedef struct packed {
        t_geo g;
        logic dneg;
        logic dzero;
    } t_sb1;

    typedef struct packed {
        logic [CB-1:0]          sx;
        logic [CB-1:0]          sy;
        logic signed [DW-1:0]   dx;
        logic signed [DW-1:0]   dy;
        logic                   h1;
        logic                   h2;
        logic                   vert;
    } t_sb2;

    function automatic logic signed [OW-1:0] f_point(input logic [CB-1:0] s,
                                                     input logic signed [MW-1:0] m);
        logic signed [PW-1:0] num;
        logic signed [PW-1:0] adj;
        logic signed [PW-1:0] res;
        num = ($signed(PW'(s)) <<< FB) + PW'(m);
        adj = num[PW-1] ? num + $signed(PW'((1 << FB) - 1)) : num;
        res = adj >>> FB;
        priority if (res < sci_pkg::OUT_MIN) begin
            f_point = OW'(sci_pkg::OUT_MIN);
        end else if (res > sci_pkg::OUT_MAX) begin
            f_point = OW'(sci_pkg::OUT_MAX);
        end else begin
            f_point = OW'(res);
        end
    endfunction

    sci_pkg::t_pipe_ctl pipe_ctl;

    logic [5:0]             r_vf;
    logic [CB-1:0]          r_sx1, r_sy1;
    logic signed [DW-1:0]   r_dx1, r_dy1, r_px1, r_py1;
    logic [sci_pkg::RAD_W-1:0] r_rad1;

    logic [CB-1:0]          r_sx2, r_sy2;
    logic signed [DW-1:0]   r_dx2, r_dy2;
    logic                   r_vert2;
    logic signed [PRW-1:0]  r_dxx2, r_dyy2, r_pdx2, r_pdy2, r_pxx2, r_pyy2;
    logic [RRW-1:0]         r_rr2;

    logic [PRW-1:0]         n_s3;
    t_geo                   r_g3, r_g4, r_g5, r_g6;
    logic signed [CW-1:0]   r_c8_3;

    logic [BBW-1:0]         r_bb4;
    logic [AW+CLW-1:0]      r_aclo4;
    logic signed [HPW-1:0]  r_achi4;

    logic signed [D8W-1:0]  r_bb5, r_ac5, r_d6;

    t_sb1                   r_sb1 [0:LSQ-1];
    logic [LSQ-1:0]         r_sv1;
    logic [SW-1:0]          sq_root;
    t_sb1                   sb1_out;

    logic signed [TW-1:0]   n_mb, n_sr, n_tp, n_tm, n_t1, n_t2;
    logic [DNW-1:0]         n_lim;
    logic                   n_in1, n_in2, n_ok, n_h1, n_h2;

    logic                   r_v7;
    logic signed [TW-1:0]   r_t1_7, r_t2_7;
    logic [DNW-1:0]         r_lim7;
    t_sb2                   r_sb7;

    logic signed [QW:0]     q1, q2;
    t_sb2                   r_sb2 [0:LDV-1];
    logic [LDV-1:0]         r_sv2;
    t_sb2                   sb2_out;

    logic                   r_v8;
    t_sb2                   r_sb8;
    logic signed [MW-1:0]   r_mx1, r_my1, r_mx2, r_my2;

    logic signed [OW-1:0]   n_p1x, n_p1y, n_p2x, n_p2y;

    logic                   r_vo;
    logic [sci_pkg::CNT_W-1:0] r_cnt;
    logic signed [OW-1:0]   r_fx, r_fy, r_sx, r_sy;
    logic                   r_vflag;

    assign pipe_ctl.en = !(r_vo && i_stall);
    assign o_stall     = !pipe_ctl.en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf  <= '0;
            r_sv1 <= '0;
            r_v7  <= 1'b0;
            r_sv2 <= '0;
            r_v8  <= 1'b0;
            r_vo  <= 1'b0;
        end else if (pipe_ctl.en) begin
            r_vf  <= {r_vf[4:0], i_valid};
            r_sv1 <= {r_sv1[LSQ-2:0], r_vf[5]};
            r_v7  <= r_sv1[LSQ-1];
            r_sv2 <= {r_sv2[LDV-2:0], r_v7};
            r_v8  <= r_sv2[LDV-1];
            r_vo  <= r_v8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_ctl.en) begin
            r_sx1  <= i_start_x;
            r_sy1  <= i_start_y;
            r_dx1  <= $signed({1'b0, i_end_x}) - $signed({1'b0, i_start_x});
            r_dy1  <= $signed({1'b0, i_end_y}) - $signed({1'b0, i_start_y});
            r_px1  <= $signed({1'b0, i_start_x}) - $signed({1'b0, i_circle_x});
            r_py1  <= $signed({1'b0, i_start_y}) - $signed({1'b0, i_circle_y});
            r_rad1 <= i_circle_radius;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_ctl.en) begin
            r_sx2   <= r_sx1;
            r_sy2   <= r_sy1;
            r_dx2   <= r_dx1;
            r_dy2   <= r_dy1;
            r_vert2 <= (r_dx1 == '0);
            r_dxx2  <= r_dx1 * r_dx1;
            r_dyy2  <= r_dy1 * r_dy1;
            r_pdx2  <= r_px1 * r_dx1;
            r_pdy2  <= r_py1 * r_dy1;
            r_pxx2  <= r_px1 * r_px1;
            r_pyy2  <= r_py1 * r_py1;
            r_rr2   <= r_rad1 * r_rad1;
        end
    end

    assign n_s3 = PRW'(r_pxx2 + r_pyy2);

    always_ff @(posedge i_clk) begin
        if (pipe_ctl.en) begin
            r_g3.sx   <= r_sx2;
            r_g3.sy   <= r_sy2;
            r_g3.dx   <= r_dx2;
            r_g3.dy   <= r_dy2;
            r_g3.vert <= r_vert2;
            r_g3.a    <= AW'(r_dxx2 + r_dyy2);
            r_g3.b    <= BW'(r_pdx2 + r_pdy2);
            r_c8_3    <= $signed((CW'(n_s3) << 8) - CW'(r_rr2));
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_ctl.en) begin
            r_g4    <= r_g3;
            r_bb4   <= r_g3.b * r_g3.b;
            r_aclo4 <= r_g3.a * r_c8_3[CLW-1:0];
            r_achi4 <= $signed({1'b0, r_g3.a}) * $signed(r_c8_3[CW-1:CLW]);
            r_g5    <= r_g4;
            r_bb5   <= $signed(D8W'(r_bb4) << 8);
            r_ac5   <= $signed((D8W'(r_achi4) << CLW) + D8W'(r_aclo4));
            r_g6    <= r_g5;
            r_d6    <= r_bb5 - r_ac5;
        end
    end

    sci_sqrt #(
        .SW (SW)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_ctl      (pipe_ctl),
        .i_radicand (r_d6[SRW-1:0]),
        .o_root     (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (pipe_ctl.en) begin
            r_sb1[0].g     <= r_g6;
            r_sb1[0].dneg  <= r_d6[D8W-1];
            r_sb1[0].dzero <= (r_d6 == '0);
            for (int k = 1; k < LSQ; k++) begin
                r_sb1[k] <= r_sb1[k-1];
            end
        end
    end

    assign sb1_out = r_sb1[LSQ-1];

    always_comb begin
        n_mb  = -(TW'(sb1_out.g.b) <<< 4);
        n_sr  = $signed(TW'(sq_root));
        n_tp  = n_mb + n_sr;
        n_tm  = n_mb - n_sr;
        n_t1  = sb1_out.g.dx[DW-1] ? n_tm : n_tp;
        n_t2  = sb1_out.g.dx[DW-1] ? n_tp : n_tm;
        n_lim = {sb1_out.g.a, 4'b0000};
        n_in1 = (n_t1 > 0) && (n_t1 < $signed({1'b0, n_lim}));
        n_in2 = (n_t2 > 0) && (n_t2 < $signed({1'b0, n_lim}));
        n_ok  = !sb1_out.g.vert && !sb1_out.dneg;
        n_h1  = n_ok && (sb1_out.dzero || n_in1);
        n_h2  = n_ok && !sb1_out.dzero && n_in2;
    end

    always_ff @(posedge i_clk) begin
        if (pipe_ctl.en) begin
            r_t1_7     <= n_t1;
            r_t2_7     <= n_t2;
            r_lim7     <= n_lim;
            r_sb7.sx   <= sb1_out.g.sx;
            r_sb7.sy   <= sb1_out.g.sy;
            r_sb7.dx   <= sb1_out.g.dx;
            r_sb7.dy   <= sb1_out.g.dy;
            r_sb7.h1   <= n_h1;
            r_sb7.h2   <= n_h2;
            r_sb7.vert <= sb1_out.g.vert;
        end
    end

    sci_div #(
        .TW  (TW),
        .FB  (FB),
        .QW  (QW),
        .DNW (DNW)
    ) u_div_first (
        .i_clk  (i_clk),
        .i_ctl  (pipe_ctl),
        .i_num  (r_t1_7),
        .i_den  (r_lim7),
        .o_quot (q1)
    );

    sci_div #(
        .TW  (TW),
        .FB  (FB),
        .QW  (QW),
        .DNW (DNW)
    ) u_div_second (
        .i_clk  (i_clk),
        .i_ctl  (pipe_ctl),
        .i_num  (r_t2_7),
        .i_den  (r_lim7),
        .o_quot (q2)
    );

    always_ff @(posedge i_clk) begin
        if (pipe_ctl.en) begin
            r_sb2[0] <= r_sb7;
            for (int k = 1; k < LDV; k++) begin
                r_sb2[k] <= r_sb2[k-1];
            end
        end
    end

    assign sb2_out = r_sb2[LDV-1];

    always_ff @(posedge i_clk) begin
        if (pipe_ctl.en) begin
            r_sb8 <= sb2_out;
            r_mx1 <= sb2_out.dx * q1;
            r_my1 <= sb2_out.dy * q1;
            r_mx2 <= sb2_out.dx * q2;
            r_my2 <= sb2_out.dy * q2;
        end
    end

    always_comb begin
        n_p1x = f_point(r_sb8.sx, r_mx1);
        n_p1y = f_point(r_sb8.sy, r_my1);
        n_p2x = f_point(r_sb8.sx, r_mx2);
        n_p2y = f_point(r_sb8.sy, r_my2);
    end

    always_ff @(posedge i_clk) begin
        if (pipe_ctl.en) begin
            r_cnt   <= {1'b0, r_sb8.h1} + {1'b0, r_sb8.h2};
            r_vflag <= r_sb8.vert;
            priority if (r_sb8.h1) begin
                r_fx <= n_p1x;
                r_fy <= n_p1y;
            end else if (r_sb8.h2) begin
                r_fx <= n_p2x;
                r_fy <= n_p2y;
            end else begin
                r_fx <= '0;
                r_fy <= '0;
            end
            if (r_sb8.h1 && r_sb8.h2) begin
                r_sx <= n_p2x;
                r_sy <= n_p2y;
            end else begin
                r_sx <= '0;
                r_sy <= '0;
            end
        end
    end

    assign o_valid         = r_vo;
    assign o_hit_count     = r_cnt;
    assign o_first_x       = r_fx;
    assign o_first_y       = r_fy;
    assign o_second_x      = r_sx;
    assign o_second_y      = r_sy;
    assign o_vertical_flag = r_vflag;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hit_count != 2'd3))
        else $error("hit count out of range");

    a_vertical_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_vertical_flag) |-> (o_hit_count == '0 && o_first_x == '0
                                          && o_first_y == '0))
        else $error("vertical segment reported a point");

    a_second_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit_count != 2'd2) |-> (o_second_x == '0 && o_second_y == '0))
        else $error("second point set without two hits");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && i_stall) |=> ($stable(r_sv1) && $stable(r_sv2) && $stable(r_vf)))
        else $error("pipeline moved while output stalled");

endmodule
